@@ hw/rtl/esckd_pkg.sv @@
// Shared types, key codes and lookup functions for the escape sequence key decoder.
package esckd_pkg;

    // Byte values that steer the decoder
    localparam logic [7:0] BYTE_ESC   = 8'h1B;
    localparam logic [7:0] BYTE_LBRKT = 8'h5B;  // '['
    localparam logic [7:0] BYTE_SS3   = 8'h4F;  // 'O'
    localparam logic [7:0] BYTE_TILDE = 8'h7E;  // '~'
    localparam logic [7:0] BYTE_SEMI  = 8'h3B;  // ';'
    localparam logic [7:0] BYTE_DEL   = 8'h7F;
    localparam logic [7:0] BYTE_BS    = 8'h08;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_DC3   = 8'h13;
    localparam logic [7:0] BYTE_DC2   = 8'h12;
    localparam logic [7:0] CHR_0      = 8'h30;
    localparam logic [7:0] CHR_1      = 8'h31;
    localparam logic [7:0] CHR_2      = 8'h32;
    localparam logic [7:0] CHR_3      = 8'h33;
    localparam logic [7:0] CHR_4      = 8'h34;
    localparam logic [7:0] CHR_5      = 8'h35;
    localparam logic [7:0] CHR_6      = 8'h36;
    localparam logic [7:0] CHR_7      = 8'h37;
    localparam logic [7:0] CHR_8      = 8'h38;
    localparam logic [7:0] CHR_9      = 8'h39;
    localparam logic [7:0] CHR_UA     = 8'h41;  // 'A'
    localparam logic [7:0] CHR_UB     = 8'h42;
    localparam logic [7:0] CHR_UC     = 8'h43;
    localparam logic [7:0] CHR_UD     = 8'h44;
    localparam logic [7:0] CHR_UF     = 8'h46;
    localparam logic [7:0] CHR_UH     = 8'h48;
    localparam logic [7:0] CHR_UR     = 8'h52;
    localparam logic [7:0] CHR_US     = 8'h53;
    localparam logic [7:0] CHR_LR     = 8'h72;  // 'r'
    localparam logic [7:0] CHR_LS     = 8'h73;  // 's'

    // Key codes
    localparam int unsigned KEY_W = 9;
    localparam int unsigned MOD_W = 3;
    localparam logic [KEY_W-1:0] KEY_NONE   = 9'd0;
    localparam logic [KEY_W-1:0] KEY_ESC    = 9'd256;
    localparam logic [KEY_W-1:0] KEY_DEL    = 9'd257;
    localparam logic [KEY_W-1:0] KEY_RET    = 9'd258;
    localparam logic [KEY_W-1:0] KEY_UP     = 9'd259;
    localparam logic [KEY_W-1:0] KEY_DOWN   = 9'd260;
    localparam logic [KEY_W-1:0] KEY_RIGHT  = 9'd261;
    localparam logic [KEY_W-1:0] KEY_LEFT   = 9'd262;
    localparam logic [KEY_W-1:0] KEY_HOME   = 9'd263;
    localparam logic [KEY_W-1:0] KEY_END    = 9'd264;
    localparam logic [KEY_W-1:0] KEY_INSERT = 9'd265;
    localparam logic [KEY_W-1:0] KEY_DELETE = 9'd266;
    localparam logic [KEY_W-1:0] KEY_PRIOR  = 9'd267;
    localparam logic [KEY_W-1:0] KEY_NEXT   = 9'd268;
    localparam logic [KEY_W-1:0] KEY_F3     = 9'd269;
    localparam logic [KEY_W-1:0] KEY_F4     = 9'd270;

    // Modifier bits
    localparam logic [MOD_W-1:0] MOD_NONE  = 3'b000;
    localparam logic [MOD_W-1:0] MOD_SHIFT = 3'b001;
    localparam logic [MOD_W-1:0] MOD_CTRL  = 3'b010;
    localparam logic [MOD_W-1:0] MOD_META  = 3'b100;

    // Stream widths
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned S_USER_W = 2;
    localparam int unsigned M_DATA_W = 16;
    localparam int unsigned M_USER_W = 1;

    // Position inside an escape sequence
    typedef enum logic [6:0] {
        PH_IDLE       = 7'b0000001,
        PH_ESC        = 7'b0000010,
        PH_SECOND     = 7'b0000100,
        PH_CSI_D      = 7'b0001000,
        PH_CSI_DD     = 7'b0010000,
        PH_CSI_SEMI   = 7'b0100000,
        PH_CSI_SEMI_M = 7'b1000000
    } phase_t;

    // One decoded result between the decode stage and the output register
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key_code;
        logic [MOD_W-1:0] modifiers;
        logic             passthrough;
    } result_t;

    typedef struct packed {
        logic             hit;
        logic [KEY_W-1:0] code;
        logic [MOD_W-1:0] mods;
    } meta_t;

    // Byte after a lone ESC that forms a Meta key (digits included)
    function automatic meta_t meta_lookup(input logic [7:0] b);
        meta_t m;
        m.hit  = 1'b1;
        m.code = {1'b0, b};
        m.mods = MOD_META;
        case (b) inside
            "f", "b", "d", "g", "h", "v", "w", "q", "t", "y",
            "%", "@", ";", ":", "x", "^", "u", "l", "c", "!",
            "|", "<", ">", "{", "}", "m", "a", "e", "r", "\\",
            " ", "z", "p", "n", "-", [CHR_0:CHR_9]: ;
            BYTE_DEL, BYTE_BS: m.code = KEY_DEL;
            BYTE_CR, BYTE_LF:  m.code = KEY_RET;
            BYTE_DC3:
            begin
                m.code = {1'b0, CHR_LS};
                m.mods = MOD_META | MOD_CTRL;
            end
            BYTE_DC2:
            begin
                m.code = {1'b0, CHR_LR};
                m.mods = MOD_META | MOD_CTRL;
            end
            default:
            begin
                m.hit  = 1'b0;
                m.code = KEY_NONE;
                m.mods = MOD_NONE;
            end
        endcase
        return m;
    endfunction

    // Cursor letter after ESC [ or ESC [ 1 ; M; KEY_NONE if not one
    function automatic logic [KEY_W-1:0] cursor_letter(input logic [7:0] b);
        logic [KEY_W-1:0] k;
        case (b)
            CHR_UA:  k = KEY_UP;
            CHR_UB:  k = KEY_DOWN;
            CHR_UC:  k = KEY_RIGHT;
            CHR_UD:  k = KEY_LEFT;
            CHR_UH:  k = KEY_HOME;
            CHR_UF:  k = KEY_END;
            default: k = KEY_NONE;
        endcase
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CHR_0) && (b <= CHR_9);
    endfunction

endpackage

@@ hw/rtl/esckd_step.sv @@
// Sequence state registers and the per-byte decode logic.
module esckd_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 timeout,
    input  logic                 raw,
    output esckd_pkg::result_t   result
);
    import esckd_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] second_reg, second_next;
    logic [KEY_W-1:0] cur_k;
    meta_t      meta;

    assign meta  = meta_lookup(data_byte);
    assign cur_k = cursor_letter(data_byte);

    // Next state and result for the word on the input
    always_comb
    begin
        phase_next         = phase_reg;
        first_next         = first_reg;
        second_next        = second_reg;
        result.valid       = 1'b0;
        result.key_code    = KEY_ESC;
        result.modifiers   = MOD_NONE;
        result.passthrough = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (!timeout)
                begin
                    if (raw || data_byte != BYTE_ESC)
                    begin
                        result.valid       = 1'b1;
                        result.key_code    = {1'b0, data_byte};
                        result.passthrough = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_ESC;
                    end
                end
            end
            PH_ESC:
            begin
                if (timeout)
                    result.valid = 1'b1;
                else if (meta.hit)
                begin
                    result.valid     = 1'b1;
                    result.key_code  = meta.code;
                    result.modifiers = meta.mods;
                end
                else
                begin
                    first_next = data_byte;
                    phase_next = PH_SECOND;
                end
            end
            PH_SECOND:
            begin
                result.valid = 1'b1;
                if (timeout)
                    ;
                else if (first_reg == BYTE_LBRKT)
                begin
                    if (is_digit(data_byte))
                    begin
                        result.valid = 1'b0;
                        first_next   = data_byte;
                        phase_next   = PH_CSI_D;
                    end
                    else if (cur_k != KEY_NONE)
                        result.key_code = cur_k;
                end
                else if (first_reg == BYTE_SS3)
                begin
                    case (data_byte)
                        CHR_UH:  result.key_code = KEY_HOME;
                        CHR_UF:  result.key_code = KEY_END;
                        CHR_UR:  result.key_code = KEY_F3;
                        CHR_US:  result.key_code = KEY_F4;
                        default: result.key_code = KEY_ESC;
                    endcase
                end
            end
            PH_CSI_D:
            begin
                result.valid = 1'b1;
                if (timeout)
                    ;
                else if (data_byte == BYTE_TILDE)
                begin
                    case (first_reg) inside
                        CHR_1, CHR_7: result.key_code = KEY_HOME;
                        CHR_2:        result.key_code = KEY_INSERT;
                        CHR_3:        result.key_code = KEY_DELETE;
                        CHR_4, CHR_8: result.key_code = KEY_END;
                        CHR_5:        result.key_code = KEY_PRIOR;
                        CHR_6:        result.key_code = KEY_NEXT;
                        default:      result.key_code = KEY_ESC;
                    endcase
                end
                else if (is_digit(data_byte))
                begin
                    result.valid = 1'b0;
                    second_next  = data_byte;
                    phase_next   = PH_CSI_DD;
                end
                else if (data_byte == BYTE_SEMI)
                begin
                    result.valid = 1'b0;
                    phase_next   = PH_CSI_SEMI;
                end
            end
            PH_CSI_DD:
            begin
                result.valid = 1'b1;
                if (!timeout && data_byte == BYTE_TILDE && first_reg == CHR_1)
                begin
                    if (second_reg == CHR_3)
                        result.key_code = KEY_F3;
                    else if (second_reg == CHR_4)
                        result.key_code = KEY_F4;
                end
            end
            PH_CSI_SEMI:
            begin
                if (timeout)
                    result.valid = 1'b1;
                else
                begin
                    second_next = data_byte;
                    phase_next  = PH_CSI_SEMI_M;
                end
            end
            PH_CSI_SEMI_M:
            begin
                result.valid = 1'b1;
                if (timeout)
                    ;
                else if (first_reg == CHR_1 && (second_reg == CHR_5 || second_reg == CHR_2))
                begin
                    if (cur_k != KEY_NONE)
                    begin
                        result.key_code  = cur_k;
                        result.modifiers = (second_reg == CHR_5) ? MOD_CTRL : MOD_SHIFT;
                    end
                end
                else if (data_byte == BYTE_TILDE)
                begin
                    if (first_reg == CHR_2 && second_reg == CHR_2)
                    begin
                        result.key_code  = KEY_INSERT;
                        result.modifiers = MOD_SHIFT;
                    end
                    else if (first_reg == CHR_2 && second_reg == CHR_5)
                    begin
                        result.key_code  = KEY_INSERT;
                        result.modifiers = MOD_CTRL;
                    end
                    else if (first_reg == CHR_3 && second_reg == CHR_2)
                    begin
                        result.key_code  = KEY_DELETE;
                        result.modifiers = MOD_SHIFT;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // A finished sequence returns to idle with cleared parameters
        if (result.valid && !result.passthrough)
        begin
            phase_next  = PH_IDLE;
            first_next  = 8'd0;
            second_next = 8'd0;
        end
    end

    // State registers advance only on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            first_reg  <= 8'd0;
            second_reg <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

endmodule

@@ hw/rtl/esckd_out_reg.sv @@
// Result register on the master side with its handshake.
module esckd_out_reg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  esckd_pkg::result_t             result,
    output logic                           in_ready,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [esckd_pkg::M_DATA_W-1:0] m_tdata,
    output logic [esckd_pkg::M_USER_W-1:0] m_tuser
);
    import esckd_pkg::*;

    localparam int unsigned PAD_W = M_DATA_W - KEY_W - MOD_W;

    logic             valid_reg;
    logic [KEY_W-1:0] key_reg;
    logic [MOD_W-1:0] mod_reg;
    logic             pass_reg;

    // A new word may enter whenever the held result leaves or none is held
    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept && result.valid)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept && result.valid)
        begin
            key_reg  <= result.key_code;
            mod_reg  <= result.modifiers;
            pass_reg <= result.passthrough;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, mod_reg, key_reg};
    assign m_tuser  = pass_reg;

endmodule

@@ hw/rtl/escape_sequence_key_decoder.sv @@
// Top level of the escape sequence key decoder.
// A result word is on m_tvalid in the cycle after its input word is accepted.
// Throughput: one input word per cycle; s_tready falls only while a result is held
// in the output register and m_tready is low.
// Reset (rst_n low, asynchronous): parser returns to idle with cleared parameters,
// and the output register is emptied.
module escape_sequence_key_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [esckd_pkg::S_DATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  logic [esckd_pkg::S_USER_W-1:0] s_tuser,  // [0] timeout, [1] raw
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [esckd_pkg::M_DATA_W-1:0] m_tdata,  // [8:0] key_code, [11:9] modifiers, rest 0
    output logic [esckd_pkg::M_USER_W-1:0] m_tuser   // [0] passthrough
);
    import esckd_pkg::*;

    logic    accept;
    result_t result;

    assign accept = s_tvalid && s_tready;

    esckd_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (s_tdata[7:0]),
        .timeout   (s_tuser[0]),
        .raw       (s_tuser[1]),
        .result    (result)
    );

    esckd_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .result   (result),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ hw/rtl/esckd_checker.sv @@
// Port-level checks for the escape sequence key decoder, bound to the top level.
module esckd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [esckd_pkg::M_DATA_W-1:0] m_tdata,
    input logic [esckd_pkg::M_USER_W-1:0] m_tuser
);
    import esckd_pkg::*;

    // A stalled result word stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // Input side is held off only by a stalled result
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output register occupancy");

    // A fresh result needs an accepted input word in the cycle before
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !($past(m_tvalid) && !$past(m_tready)) |-> $past(s_tvalid && s_tready))
        else $error("result word without an accepted input word");

    // A passed-on byte carries no modifiers and a plain byte code; padding is zero
    a_plain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:12] == 4'd0) &&
                     (!m_tuser[0] || (m_tdata[11:8] == 4'd0)))
        else $error("malformed result word");

endmodule

bind escape_sequence_key_decoder esckd_checker u_esckd_checker (.*);

@@ tb/escape_sequence_key_decoder_checker.sv @@
// Checker for the escape sequence key decoder: predicts key events and compares results.
module escape_sequence_key_decoder_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [esckd_pkg::S_DATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  logic [esckd_pkg::S_USER_W-1:0] s_tuser,  // [0] timeout, [1] raw
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [esckd_pkg::M_DATA_W-1:0] m_tdata,  // [8:0] key_code, [11:9] modifiers
    input  logic [esckd_pkg::M_USER_W-1:0] m_tuser,  // [0] passthrough
    output int                             errors,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import esckd_pkg::*;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [MOD_W-1:0] mods;
        logic             plain;
    } key_event_t;

    // Predicted parser state
    phase_t      seq_phase;
    logic [7:0]  param_a;
    logic [7:0]  param_b;

    key_event_t  expected_keys[$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    function automatic logic [KEY_W-1:0] arrow_key(input logic [7:0] b);
        case (b)
            CHR_UA:  return KEY_UP;
            CHR_UB:  return KEY_DOWN;
            CHR_UC:  return KEY_RIGHT;
            CHR_UD:  return KEY_LEFT;
            CHR_UH:  return KEY_HOME;
            CHR_UF:  return KEY_END;
            default: return KEY_NONE;
        endcase
    endfunction

    function automatic logic numeral(input logic [7:0] b);
        return (b >= CHR_0) && (b <= CHR_9);
    endfunction

    // Meta key formed by ESC followed by b; plain = 1 marks a miss
    function automatic key_event_t meta_event(input logic [7:0] b);
        key_event_t ev;
        ev = '{key: {1'b0, b}, mods: MOD_META, plain: 1'b0};
        case (b)
            "f", "b", "d", "g", "h", "v", "w", "q", "t", "y",
            "%", "@", ";", ":", "x", "^", "u", "l", "c", "!",
            "|", "<", ">", "{", "}", "m", "a", "e", "r", "\\",
            " ", "z", "p", "n", "-": ;
            BYTE_DEL, BYTE_BS: ev.key = KEY_DEL;
            BYTE_CR, BYTE_LF:  ev.key = KEY_RET;
            BYTE_DC3:
            begin
                ev.key  = {1'b0, CHR_LS};
                ev.mods = MOD_META | MOD_CTRL;
            end
            BYTE_DC2:
            begin
                ev.key  = {1'b0, CHR_LR};
                ev.mods = MOD_META | MOD_CTRL;
            end
            default:
                if (!numeral(b))
                    ev.plain = 1'b1;
        endcase
        return ev;
    endfunction

    // Advance the predicted parser by one word; hit says a key event is due
    task automatic decode_word(input logic [7:0] b, input logic tmo, input logic rw,
                               output logic hit, output key_event_t ev);
        logic [KEY_W-1:0] k;
        logic             done;
        hit  = 1'b0;
        done = 1'b0;
        ev   = '{key: KEY_ESC, mods: MOD_NONE, plain: 1'b0};
        if (seq_phase == PH_IDLE)
        begin
            if (!tmo)
            begin
                if (rw || b != BYTE_ESC)
                begin
                    ev  = '{key: {1'b0, b}, mods: MOD_NONE, plain: 1'b1};
                    hit = 1'b1;
                end
                else
                    seq_phase = PH_ESC;
            end
        end
        else if (tmo)
            done = 1'b1;
        else
        begin
            case (seq_phase)
                PH_ESC:
                begin
                    ev = meta_event(b);
                    if (!ev.plain)
                        done = 1'b1;
                    else
                    begin
                        param_a   = b;
                        seq_phase = PH_SECOND;
                    end
                end
                PH_SECOND:
                begin
                    done = 1'b1;
                    if (param_a == BYTE_LBRKT)
                    begin
                        if (numeral(b))
                        begin
                            param_a   = b;
                            seq_phase = PH_CSI_D;
                            done      = 1'b0;
                        end
                        else
                        begin
                            k = arrow_key(b);
                            if (k != KEY_NONE)
                                ev.key = k;
                        end
                    end
                    else if (param_a == BYTE_SS3)
                    begin
                        case (b)
                            CHR_UH:  ev.key = KEY_HOME;
                            CHR_UF:  ev.key = KEY_END;
                            CHR_UR:  ev.key = KEY_F3;
                            CHR_US:  ev.key = KEY_F4;
                            default: ;
                        endcase
                    end
                end
                PH_CSI_D:
                begin
                    if (b == BYTE_TILDE)
                    begin
                        done = 1'b1;
                        case (param_a)
                            CHR_1, CHR_7: ev.key = KEY_HOME;
                            CHR_2:        ev.key = KEY_INSERT;
                            CHR_3:        ev.key = KEY_DELETE;
                            CHR_4, CHR_8: ev.key = KEY_END;
                            CHR_5:        ev.key = KEY_PRIOR;
                            CHR_6:        ev.key = KEY_NEXT;
                            default:      ;
                        endcase
                    end
                    else if (numeral(b))
                    begin
                        param_b   = b;
                        seq_phase = PH_CSI_DD;
                    end
                    else if (b == BYTE_SEMI)
                        seq_phase = PH_CSI_SEMI;
                    else
                        done = 1'b1;
                end
                PH_CSI_DD:
                begin
                    done = 1'b1;
                    if (b == BYTE_TILDE && param_a == CHR_1)
                    begin
                        if (param_b == CHR_3)
                            ev.key = KEY_F3;
                        else if (param_b == CHR_4)
                            ev.key = KEY_F4;
                    end
                end
                PH_CSI_SEMI:
                begin
                    param_b   = b;
                    seq_phase = PH_CSI_SEMI_M;
                end
                default:
                begin
                    // ESC [ d ; m followed by the final byte
                    done = 1'b1;
                    if (param_a == CHR_1 && (param_b == CHR_5 || param_b == CHR_2))
                    begin
                        k = arrow_key(b);
                        if (k != KEY_NONE)
                        begin
                            ev.key  = k;
                            ev.mods = (param_b == CHR_5) ? MOD_CTRL : MOD_SHIFT;
                        end
                    end
                    else if (b == BYTE_TILDE)
                    begin
                        if (param_a == CHR_2 && param_b == CHR_2)
                            ev = '{key: KEY_INSERT, mods: MOD_SHIFT, plain: 1'b0};
                        else if (param_a == CHR_2 && param_b == CHR_5)
                            ev = '{key: KEY_INSERT, mods: MOD_CTRL, plain: 1'b0};
                        else if (param_a == CHR_3 && param_b == CHR_2)
                            ev = '{key: KEY_DELETE, mods: MOD_SHIFT, plain: 1'b0};
                    end
                end
            endcase
        end
        // Sequence complete: back to idle with cleared parameters
        if (done)
        begin
            hit       = 1'b1;
            seq_phase = PH_IDLE;
            param_a   = 8'h00;
            param_b   = 8'h00;
        end
    endtask

    task automatic flag(input string what, input int want, input int got);
        if (errors < 10)
            $display("mismatch in %s at %0t: expected %0d, actual %0d", what, $realtime,
                     want, got);
        errors++;
    endtask

    // Compare each result word with the oldest prediction, then predict from the input word
    always @(posedge clk or negedge rst_n)
    begin : watch
        logic       hit;
        key_event_t ev;
        key_event_t want;
        if (!rst_n)
        begin
            seq_phase = PH_IDLE;
            param_a   = 8'h00;
            param_b   = 8'h00;
            expected_keys.delete();
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_keys.size() == 0)
                    flag("unexpected result word, key_code", -1, m_tdata[8:0]);
                else
                begin
                    want = expected_keys.pop_front();
                    if (m_tdata[8:0] != want.key)
                        flag("key_code", want.key, m_tdata[8:0]);
                    if (m_tdata[11:9] != want.mods)
                        flag("modifiers", want.mods, m_tdata[11:9]);
                    if (m_tuser[0] != want.plain)
                        flag("passthrough", want.plain, m_tuser[0]);
                    if (m_tdata[M_DATA_W-1:12] != '0)
                        flag("tdata padding", 0, m_tdata[M_DATA_W-1:12]);
                end
            end
            if (s_tvalid && s_tready)
            begin
                decode_word(s_tdata[7:0], s_tuser[0], s_tuser[1], hit, ev);
                if (hit)
                    expected_keys.push_back(ev);
            end
            pending <= expected_keys.size();
        end
    end

endmodule

@@ tb/escape_sequence_key_decoder_test.sv @@
// Testbench top for the escape sequence key decoder: clock, reset, stimulus and verdict.
module escape_sequence_key_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import esckd_pkg::*;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;   // [7:0] data_byte
    logic [S_USER_W-1:0]   s_tuser  = '0;   // [0] timeout, [1] raw
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;         // [8:0] key_code, [11:9] modifiers
    logic [M_USER_W-1:0]   m_tuser;         // [0] passthrough

    logic                  gaps_on  = 1'b1;
    int                    words_sent = 0;
    int                    errors;
    int                    pending;

    escape_sequence_key_decoder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    escape_sequence_key_decoder_checker checker_0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Result side: random back-pressure while gaps are enabled
    always @(posedge clk)
        m_tready <= gaps_on ? ($urandom_range(0, 99) >= 13) : 1'b1;

    // Offer one word, with optional idle cycles first, and wait for its acceptance
    task automatic send_word(input logic [7:0] b, input logic tmo, input logic rw);
        while (gaps_on && $urandom_range(0, 99) < 13)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {rw, tmo};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0, (i == 0) ? 1'b0 : 1'($urandom_range(0, 1)));
    endtask

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // Mostly the wanted byte, now and then any byte at all
    function automatic logic [7:0] tail(input string s);
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom);
        return pick(s);
    endfunction

    // One random lone byte, timeout word or sequence: mostly well formed, some cut short or corrupted
    task automatic send_random_sequence();
        logic [7:0] seq[$];
        logic [7:0] d;
        int         kind;
        int         cut;
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            send_word(8'($urandom), 1'b0, $urandom_range(0, 3) == 0);
            return;
        end
        if (kind < 20)
        begin
            send_word(8'($urandom), 1'b1, 1'($urandom_range(0, 1)));
            return;
        end
        seq.push_back(BYTE_ESC);
        if (kind < 35)
        begin
            case ($urandom_range(0, 3))
                0:       seq.push_back(pick("fbdghvwqty%@;:x^ulc!|<>{}maer\\ zpn-"));
                1:       seq.push_back(pick("\177\010\015\012\023\022"));
                2:       seq.push_back(pick("0123456789"));
                default:
                begin
                    seq.push_back(8'($urandom));
                    seq.push_back(8'($urandom));
                end
            endcase
        end
        else if (kind < 50)
        begin
            seq.push_back(BYTE_LBRKT);
            seq.push_back(tail("ABCDHF"));
        end
        else if (kind < 60)
        begin
            seq.push_back(BYTE_SS3);
            seq.push_back(tail("HFRS"));
        end
        else if (kind < 75)
        begin
            seq.push_back(BYTE_LBRKT);
            seq.push_back(pick("0123456789"));
            seq.push_back(tail("~"));
        end
        else if (kind < 85)
        begin
            seq.push_back(BYTE_LBRKT);
            seq.push_back(tail("1"));
            seq.push_back(tail("34"));
            seq.push_back(tail("~"));
        end
        else
        begin
            d = tail("123");
            seq.push_back(BYTE_LBRKT);
            seq.push_back(d);
            seq.push_back(BYTE_SEMI);
            seq.push_back(tail("25"));
            seq.push_back((d == CHR_1) ? tail("ABCDHF") : tail("~"));
        end
        if ($urandom_range(0, 19) == 0)
            seq[$urandom_range(1, seq.size() - 1)] = 8'($urandom);
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, seq.size() - 1) : seq.size();
        for (int i = 0; i < cut; i++)
            send_word(seq[i], 1'b0, (i == 0) ? 1'b0 : 1'($urandom_range(0, 1)));
        if (cut < seq.size())
            send_word(8'($urandom), 1'b1, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte extremes, raw ESC, timeouts, some CSI sequences and a Meta key
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(BYTE_ESC, 1'b0, 1'b1);
        send_word(8'hA5, 1'b1, 1'b0);
        send_word(BYTE_ESC, 1'b0, 1'b0);
        send_word(8'h5A, 1'b1, 1'b1);
        send_text("\033[A");
        send_text("\033[13~");
        send_text("\033[1;5C");
        send_text("\033[3;2~");
        send_text("\033\023");

        // Random sequences, with a stretch free of idle cycles in the middle
        while (words_sent < 1950)
        begin
            gaps_on <= !(words_sent >= 800 && words_sent < 1100);
            send_random_sequence();
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Hard stop for a hung run
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
